FILE: rtl/lru_keyed_slot_cache_assert.svh
// ---------------------------------------------------------------------------
// lru_keyed_slot_cache_assert.svh
// Assertion macros shared by the checker of the keyed slot cache.
// ---------------------------------------------------------------------------
// Both macros expect signals named clk and arst_n in the using scope.
`ifndef LRU_KEYED_SLOT_CACHE_ASSERT_SVH
`define LRU_KEYED_SLOT_CACHE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LKC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define LKC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/lkc_pkg.sv
// ---------------------------------------------------------------------------
// lkc_pkg
// Types and constants of the keyed slot cache directory.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package lkc_pkg;

	localparam int CELL_W     = 20;
	localparam int VAR_W      = 2;
	localparam int STAMP_W    = 64;
	localparam int SLOT_W     = 6;
	localparam int STATUS_W   = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 21;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_READY = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CELL_LIMIT  = 1'd1;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_REFUSED = 2'd0;
	localparam logic [STATUS_W-1:0] ST_HIT     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FILLED  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FAILED  = 2'd3;

	typedef struct packed {
		logic [CELL_W-1:0] dest_cell;
		logic [VAR_W-1:0]  variant;
		logic              fill_ok;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SLOT_W-1:0]   slot_index;
	} rsp_t;

	// Stored key and stamp of one slot
	typedef struct packed {
		logic [CELL_W-1:0]  slot_cell;
		logic [VAR_W-1:0]   variant;
		logic [STAMP_W-1:0] stamp;
	} slot_word_t;

	// Slot as seen by the scan unit
	typedef struct packed {
		logic              valid;
		logic [CELL_W-1:0]  slot_cell;
		logic [VAR_W-1:0]   variant;
		logic [STAMP_W-1:0] stamp;
	} slot_entry_t;

endpackage

FILE: rtl/lru_keyed_slot_cache.sv
// ---------------------------------------------------------------------------
// lru_keyed_slot_cache
// Fully associative slot directory keyed by cell and variant, LRU by stamp.
// ---------------------------------------------------------------------------
// One request per start pulse while busy is low; busy stays high through the
// result beat. A served request runs the scan state, where the shared compare
// unit walks the slot memory one slot per cycle through its single registered
// read port and then waits out the last read and compare, then the update state
// and the done state. Busy falls after the done cycle, so a new request is
// taken only once the last result has gone out. A refused request (no level
// ready, or dest_cell at or beyond the cell limit) answers in the cycle after
// the accepting edge with status 0 and slot 0, and the next request can be
// taken once busy has fallen after that done cycle. The done strobe lasts one
// cycle and the result must be taken then; it cannot be held off.
// Configuration writes take effect at once and belong in idle time.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lru_keyed_slot_cache #(
	parameter int NUM_SLOTS = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [lkc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lkc_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                           start,
	input  lkc_pkg::req_t                  req,
	output logic                           busy,
	output logic                           done,
	output lkc_pkg::rsp_t                  rsp
);

	localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CNT_W = $clog2(NUM_SLOTS + 1);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SCAN = 4'b0010,
		S_UPD  = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t                          state_q;
	logic                            level_ready_q;
	logic [lkc_pkg::CFG_DATA_W-1:0]  cell_limit_q;
	logic [lkc_pkg::STAMP_W-1:0]     counter_q;
	lkc_pkg::req_t                   req_q;
	logic [CNT_W-1:0]                scan_q;
	lkc_pkg::rsp_t                   rsp_q;
	logic                            done_q;

	logic                  accept;
	logic                  refuse;
	logic                  issue;
	logic                  scan_end;
	logic                  clear;
	logic                  wr_en;
	logic                  inv_en;
	logic [IDX_W-1:0]      wr_addr;
	lkc_pkg::slot_word_t   wr_word;
	lkc_pkg::slot_entry_t  rd_entry;
	logic                  cmp_busy;
	logic                  hit;
	logic [IDX_W-1:0]      hit_idx;
	logic [IDX_W-1:0]      victim_idx;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_ready_q <= 1'b0;
			cell_limit_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lkc_pkg::CFG_LEVEL_READY: level_ready_q <= cfg_wdata[0];
				lkc_pkg::CFG_CELL_LIMIT:  cell_limit_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// request checks
	always_comb begin
		accept   = start && (state_q == S_IDLE);
		refuse   = !level_ready_q || ({1'b0, req.dest_cell} >= cell_limit_q);
		issue    = (state_q == S_SCAN) && (scan_q != CNT_W'(NUM_SLOTS));
		scan_end = (state_q == S_SCAN) && (scan_q == CNT_W'(NUM_SLOTS)) && !cmp_busy;
		clear    = accept;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			counter_q <= '0;
			scan_q    <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (refuse) begin
							state_q <= S_DONE;
							done_q  <= 1'b1;
						end else begin
							state_q   <= S_SCAN;
							counter_q <= counter_q + 64'd1;
							scan_q    <= '0;
						end
					end
				end
				S_SCAN: begin
					if (issue) begin
						scan_q <= scan_q + CNT_W'(1);
					end
					if (scan_end) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					state_q <= S_DONE;
					done_q  <= 1'b1;
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
			if (refuse) begin
				rsp_q.status     <= lkc_pkg::ST_REFUSED;
				rsp_q.slot_index <= '0;
			end
		end else if (state_q == S_UPD) begin
			if (hit) begin
				rsp_q.status     <= lkc_pkg::ST_HIT;
				rsp_q.slot_index <= lkc_pkg::SLOT_W'(hit_idx);
			end else begin
				rsp_q.status     <= req_q.fill_ok ? lkc_pkg::ST_FILLED : lkc_pkg::ST_FAILED;
				rsp_q.slot_index <= lkc_pkg::SLOT_W'(victim_idx);
			end
		end
	end

	// slot update: restamp on hit, fill or invalidate the victim on miss
	always_comb begin
		wr_en             = (state_q == S_UPD) && (hit || req_q.fill_ok);
		inv_en            = (state_q == S_UPD) && !hit && !req_q.fill_ok;
		wr_addr           = hit ? hit_idx : victim_idx;
		wr_word.slot_cell = req_q.dest_cell;
		wr_word.variant   = req_q.variant;
		wr_word.stamp     = counter_q;
	end

	lkc_slot_store #(
		.NUM_SLOTS(NUM_SLOTS)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (issue),
		.rd_addr  (scan_q[IDX_W-1:0]),
		.rd_entry (rd_entry),
		.wr_en    (wr_en),
		.inv_en   (inv_en),
		.wr_addr  (wr_addr),
		.wr_word  (wr_word)
	);

	lkc_scan #(
		.NUM_SLOTS(NUM_SLOTS)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.clear       (clear),
		.issue       (issue),
		.issue_idx   (scan_q[IDX_W-1:0]),
		.key_cell    (req_q.dest_cell),
		.key_variant (req_q.variant),
		.entry       (rd_entry),
		.busy_scan   (cmp_busy),
		.hit         (hit),
		.hit_idx     (hit_idx),
		.victim_idx  (victim_idx)
	);

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

FILE: rtl/lkc_slot_store.sv
// ---------------------------------------------------------------------------
// lkc_slot_store
// Slot memory with one registered read port and one write port, plus
// per-slot valid and stamped flags in flops.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lkc_slot_store #(
	parameter int NUM_SLOTS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rd_en,
	input  logic [(NUM_SLOTS > 1 ? $clog2(NUM_SLOTS) : 1)-1:0] rd_addr,
	output lkc_pkg::slot_entry_t rd_entry,
	input  logic                 wr_en,
	input  logic                 inv_en,
	input  logic [(NUM_SLOTS > 1 ? $clog2(NUM_SLOTS) : 1)-1:0] wr_addr,
	input  lkc_pkg::slot_word_t  wr_word
);

	lkc_pkg::slot_word_t    mem_q [NUM_SLOTS];
	lkc_pkg::slot_word_t    rd_word_q;
	logic [NUM_SLOTS-1:0]   valid_q;
	logic [NUM_SLOTS-1:0]   stamped_q;
	logic                   rd_valid_q;
	logic                   rd_stamped_q;

	// key/stamp storage, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_word;
		end
		if (rd_en) begin
			rd_word_q <= mem_q[rd_addr];
		end
	end

	// valid and stamped flags; an unstamped slot reads a zero stamp
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			stamped_q    <= '0;
			rd_valid_q   <= 1'b0;
			rd_stamped_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr]   <= 1'b1;
				stamped_q[wr_addr] <= 1'b1;
			end else if (inv_en) begin
				valid_q[wr_addr] <= 1'b0;
			end
			if (rd_en) begin
				rd_valid_q   <= valid_q[rd_addr];
				rd_stamped_q <= stamped_q[rd_addr];
			end
		end
	end

	always_comb begin
		rd_entry.valid     = rd_valid_q;
		rd_entry.slot_cell = rd_word_q.slot_cell;
		rd_entry.variant   = rd_word_q.variant;
		rd_entry.stamp     = rd_stamped_q ? rd_word_q.stamp : '0;
	end

endmodule

FILE: rtl/lkc_scan.sv
// ---------------------------------------------------------------------------
// lkc_scan
// Shared compare unit: takes one slot per beat, tracks the first key hit
// and the lowest-numbered slot with the smallest stamp.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lkc_scan #(
	parameter int NUM_SLOTS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 clear,
	input  logic                 issue,
	input  logic [(NUM_SLOTS > 1 ? $clog2(NUM_SLOTS) : 1)-1:0] issue_idx,
	input  logic [lkc_pkg::CELL_W-1:0] key_cell,
	input  logic [lkc_pkg::VAR_W-1:0]  key_variant,
	input  lkc_pkg::slot_entry_t entry,
	output logic                 busy_scan,
	output logic                 hit,
	output logic [(NUM_SLOTS > 1 ? $clog2(NUM_SLOTS) : 1)-1:0] hit_idx,
	output logic [(NUM_SLOTS > 1 ? $clog2(NUM_SLOTS) : 1)-1:0] victim_idx
);

	localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

	logic                         cmp_vld_s1;
	logic [IDX_W-1:0]             cmp_idx_s1;
	logic                         hit_q;
	logic [IDX_W-1:0]             hit_idx_q;
	logic [IDX_W-1:0]             victim_q;
	logic [lkc_pkg::STAMP_W-1:0]  min_stamp_q;
	logic                         match;
	logic                         older;

	// align slot index with the registered read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_vld_s1 <= 1'b0;
			cmp_idx_s1 <= '0;
		end else begin
			cmp_vld_s1 <= issue;
			cmp_idx_s1 <= issue_idx;
		end
	end

	// the compare unit: key equality and stamp less-than
	always_comb begin
		match = entry.valid && (entry.slot_cell == key_cell) &&
			(entry.variant == key_variant);
		older = (cmp_idx_s1 == '0) || (entry.stamp < min_stamp_q);
	end

	// running hit and oldest-slot trackers; strict less keeps the first tie
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q       <= 1'b0;
			hit_idx_q   <= '0;
			victim_q    <= '0;
			min_stamp_q <= '0;
		end else if (clear) begin
			hit_q <= 1'b0;
		end else if (cmp_vld_s1) begin
			if (match && !hit_q) begin
				hit_q     <= 1'b1;
				hit_idx_q <= cmp_idx_s1;
			end
			if (older) begin
				min_stamp_q <= entry.stamp;
				victim_q    <= cmp_idx_s1;
			end
		end
	end

	assign busy_scan  = cmp_vld_s1;
	assign hit        = hit_q;
	assign hit_idx    = hit_idx_q;
	assign victim_idx = victim_q;

endmodule

FILE: rtl/lkc_checker.sv
// ---------------------------------------------------------------------------
// lkc_checker
// Port-level checks of the keyed slot cache command handshake.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lru_keyed_slot_cache_assert.svh"

module lkc_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          busy,
	input  logic          done,
	input  lkc_pkg::rsp_t rsp
);

	// result beats only come while a request is in flight
	`LKC_ASSERT_NOW(a_done_busy, done, busy, "result beat while not busy")

	// a result beat lasts one cycle and frees the block
	`LKC_ASSERT_NEXT(a_done_pulse, done, !done && !busy, "result beat not a single pulse")

	// an accepted request marks the block busy
	`LKC_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted request left block idle")

	// a refused request reports slot zero
	`LKC_ASSERT_NOW(a_refused_slot, done && (rsp.status == lkc_pkg::ST_REFUSED),
		rsp.slot_index == '0, "refused result with nonzero slot")

endmodule

bind lru_keyed_slot_cache lkc_checker u_lkc_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);
